// File: rtl/tftp_data_packet_receiver_top_macros.svh
// Assertion macros used by the receiver's top-level RTL file.
`ifndef TFTP_DATA_PACKET_RECEIVER_TOP_MACROS_SVH
`define TFTP_DATA_PACKET_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TDPR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("receiver check failed");

// Next-cycle implication, checked outside reset.
`define TDPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("receiver check failed");

`endif

// File: rtl/tdpr_pkg.sv
// Types and constants of the TFTP data packet receiver.
package tdpr_pkg;

    localparam int unsigned POS_W = 10;
    localparam logic [POS_W-1:0] POS_LIMIT = 10'd1023;
    localparam logic [POS_W-1:0] HEADER_BYTES = 10'd4;
    localparam logic [7:0] OPC_DATA = 8'd3;
    localparam logic [7:0] OPC_ERROR = 8'd5;
    localparam logic [15:0] FIRST_BLOCK_RESET = 16'd1;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_DATA  = 2'd1,
        KIND_ERROR = 2'd2,
        KIND_OTHER = 2'd3
    } op_kind_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED   = 3'd0,
        ST_IGNORED    = 3'd1,
        ST_ERROR_PKT  = 3'd2,
        ST_UNEXPECTED = 3'd3,
        ST_RUNT       = 3'd4
    } pkt_status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       end_of_packet;
    } rx_beat_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        packet_end;
        logic [2:0]  packet_status;
        logic        transfer_done;
        logic [15:0] last_block_seen;
        logic [31:0] total_bytes;
        logic [31:0] total_blocks;
    } result_beat_t;

endpackage

// File: rtl/tdpr_parser.sv
// Packet parser: header decode, block check, counters and the result of one byte.
module tdpr_parser #(
    parameter int unsigned MAX_PACKET_BYTES = 516
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [15:0]            cfg_first_block,
    input  logic                   step,
    input  tdpr_pkg::rx_beat_t     rx,
    output tdpr_pkg::result_beat_t result
);
    import tdpr_pkg::*;

    logic [15:0]      expected_reg, expected_next;
    logic [31:0]      byte_total_reg, byte_total_next;
    logic [31:0]      block_total_reg, block_total_next;
    logic [15:0]      received_reg, received_next;
    logic             done_reg, done_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    op_kind_t         kind_reg, kind_next;
    logic [15:0]      asm_reg, asm_next;

    logic [POS_W-1:0] len;
    logic [32:0]      byte_sum;
    logic             payload_ok;
    pkt_status_t      status;

    always_comb begin
        expected_next    = expected_reg;
        byte_total_next  = byte_total_reg;
        block_total_next = block_total_reg;
        received_next    = received_reg;
        done_next        = done_reg;
        pos_next         = pos_reg;
        kind_next        = kind_reg;
        asm_next         = asm_reg;
        payload_ok       = 1'b0;
        status           = ST_ACCEPTED;
        byte_sum         = 33'd0;

        if (pos_reg != POS_LIMIT) begin
            if (pos_reg == 10'd1) begin
                if (rx.rx_byte == OPC_DATA) begin
                    kind_next = KIND_DATA;
                end else if (rx.rx_byte == OPC_ERROR) begin
                    kind_next = KIND_ERROR;
                end else begin
                    kind_next = KIND_OTHER;
                end
            end else if (pos_reg == 10'd2) begin
                asm_next = {rx.rx_byte, 8'h00};
            end else if (pos_reg == 10'd3) begin
                asm_next = {asm_reg[15:8], rx.rx_byte};
            end else if (pos_reg >= HEADER_BYTES) begin
                payload_ok = (kind_reg == KIND_DATA) && (asm_reg == expected_reg);
            end
            pos_next = pos_reg + 10'd1;
        end
        len = pos_next;

        if (rx.end_of_packet) begin
            if (len < HEADER_BYTES) begin
                status = ST_RUNT;
            end else if (kind_next == KIND_ERROR) begin
                status = ST_ERROR_PKT;
            end else if (kind_next != KIND_DATA) begin
                status = ST_UNEXPECTED;
            end else begin
                if ((len > HEADER_BYTES) && (asm_next == expected_reg)) begin
                    byte_sum = {1'b0, byte_total_reg} + 33'(len - HEADER_BYTES);
                    byte_total_next = byte_sum[32] ? 32'hFFFF_FFFF : byte_sum[31:0];
                    block_total_next = (block_total_reg == 32'hFFFF_FFFF) ?
                                       block_total_reg : block_total_reg + 32'd1;
                    expected_next = expected_reg + 16'd1;
                    status = ST_ACCEPTED;
                end else begin
                    status = ST_IGNORED;
                end
                if (len != POS_W'(MAX_PACKET_BYTES)) begin
                    done_next = 1'b1;
                end
                received_next = asm_next;
            end
            pos_next  = '0;
            kind_next = KIND_NONE;
            asm_next  = 16'd0;
        end
    end

    assign result.payload_byte    = payload_ok ? rx.rx_byte : 8'd0;
    assign result.payload_valid   = payload_ok;
    assign result.packet_end      = rx.end_of_packet;
    assign result.packet_status   = status;
    assign result.transfer_done   = done_next;
    assign result.last_block_seen = received_next;
    assign result.total_bytes     = byte_total_next;
    assign result.total_blocks    = block_total_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_reg    <= FIRST_BLOCK_RESET;
            byte_total_reg  <= 32'd0;
            block_total_reg <= 32'd0;
            received_reg    <= 16'd0;
            done_reg        <= 1'b0;
            pos_reg         <= '0;
            kind_reg        <= KIND_NONE;
            asm_reg         <= 16'd0;
        end else if (cfg_we) begin
            expected_reg <= cfg_first_block;
        end else if (step) begin
            expected_reg    <= expected_next;
            byte_total_reg  <= byte_total_next;
            block_total_reg <= block_total_next;
            received_reg    <= received_next;
            done_reg        <= done_next;
            pos_reg         <= pos_next;
            kind_reg        <= kind_next;
            asm_reg         <= asm_next;
        end
    end

endmodule

// File: rtl/tftp_data_packet_receiver_top.sv
// Top level of the TFTP data packet receiver with its input and result registers.
//
// The s_ channel takes one received packet byte per beat, with end_of_packet on
// the last byte of each packet. The m_ channel gives exactly one result beat for
// every input beat, in order: the payload byte when it belongs to the expected
// block, the packet status on the last byte, and the running totals.
// The cfg_ channel loads the first expected block number; it is always ready, and
// the user must write it only while no bytes are in flight; the block does not enforce this.
// An input beat is registered in the input register at acceptance, and its result is
// registered in the result register once that register is empty or being taken.
// Throughput is one byte per cycle while m_ready stays high; the parse and counter update
// is one pass of logic between the input register and the result register.
// When m_ready is low the result register holds its beat and the input register
// still takes one more byte; s_ready drops only when both registers are full.
// Reset clears the counters and flags and sets the expected block to one.
module tftp_data_packet_receiver_top #(
    parameter int unsigned MAX_PACKET_BYTES = 516
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  tdpr_pkg::rx_beat_t     s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output tdpr_pkg::result_beat_t m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data
);
    import tdpr_pkg::*;

`include "tftp_data_packet_receiver_top_macros.svh"

    logic         in_valid_reg;
    rx_beat_t     in_data_reg;
    logic         out_valid_reg;
    result_beat_t out_data_reg;
    result_beat_t result;
    logic         advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    tdpr_parser #(
        .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
    ) u_parser (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_valid),
        .cfg_first_block(cfg_data),
        .step           (advance),
        .rx             (in_data_reg),
        .result         (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    `TDPR_ASSERT_NOW(a_payload_means_accepted, aclk, aresetn,
        m_valid && m_data.payload_valid && m_data.packet_end,
        m_data.packet_status == ST_ACCEPTED)
    `TDPR_ASSERT_NOW(a_status_only_at_end, aclk, aresetn,
        m_valid && !m_data.packet_end, m_data.packet_status == ST_ACCEPTED)
    `TDPR_ASSERT_NEXT(a_done_sticky, aclk, aresetn,
        m_valid && m_data.transfer_done, m_data.transfer_done)
    `TDPR_ASSERT_NEXT(a_blocks_monotonic, aclk, aresetn,
        m_valid, m_data.total_blocks >= $past(m_data.total_blocks))

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of the TFTP data packet receiver: packet stimulus, prediction and checks.
module tb_top;
    import tdpr_pkg::*;

    localparam int unsigned PKT_MAX = 516;
    localparam int unsigned RUN_LIMIT = 1000000;
    localparam int unsigned PHASE_BYTES = 12;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    rx_beat_t s_data = '0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;
    result_beat_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [15:0] cfg_data = '0;

    tftp_data_packet_receiver_top #(
        .MAX_PACKET_BYTES(PKT_MAX)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Receiver state as the packet parser should hold it.
    logic [15:0] next_block = FIRST_BLOCK_RESET;
    logic [15:0] last_block = '0;
    logic [31:0] byte_count = '0;
    logic [31:0] block_count = '0;
    logic        done_seen = 1'b0;
    logic [9:0]  pkt_pos = '0;
    op_kind_t    pkt_kind = KIND_NONE;
    logic [15:0] pkt_block = '0;

    rx_beat_t     send_q[$];
    result_beat_t expect_q[$];
    int unsigned  errors = 0;
    int unsigned  stim_bytes = 0;
    logic [15:0]  gen_block = FIRST_BLOCK_RESET;

    bit s_taken = 1'b0;
    bit m_taken = 1'b0;
    bit send_calm = 1'b0;
    bit recv_calm = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;

    function automatic result_beat_t rx_predict(rx_beat_t beat);
        result_beat_t res;
        logic [32:0] sum;
        res = '0;
        if (pkt_pos < POS_LIMIT) begin
            if (pkt_pos == 10'd1) begin
                pkt_kind = (beat.rx_byte == OPC_DATA) ? KIND_DATA :
                           (beat.rx_byte == OPC_ERROR) ? KIND_ERROR : KIND_OTHER;
            end else if (pkt_pos == 10'd2) begin
                pkt_block = {beat.rx_byte, 8'h00};
            end else if (pkt_pos == 10'd3) begin
                pkt_block[7:0] = beat.rx_byte;
            end else if (pkt_pos >= HEADER_BYTES && pkt_kind == KIND_DATA
                         && pkt_block == next_block) begin
                res.payload_valid = 1'b1;
                res.payload_byte = beat.rx_byte;
            end
            pkt_pos = pkt_pos + 10'd1;
        end
        if (beat.end_of_packet) begin
            res.packet_end = 1'b1;
            if (pkt_pos < HEADER_BYTES) begin
                res.packet_status = ST_RUNT;
            end else if (pkt_kind == KIND_ERROR) begin
                res.packet_status = ST_ERROR_PKT;
            end else if (pkt_kind != KIND_DATA) begin
                res.packet_status = ST_UNEXPECTED;
            end else begin
                if (pkt_pos > HEADER_BYTES && pkt_block == next_block) begin
                    sum = {1'b0, byte_count} + 33'(pkt_pos - HEADER_BYTES);
                    byte_count = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    if (block_count != 32'hFFFF_FFFF) begin
                        block_count = block_count + 32'd1;
                    end
                    next_block = next_block + 16'd1;
                    res.packet_status = ST_ACCEPTED;
                end else begin
                    res.packet_status = ST_IGNORED;
                end
                if (pkt_pos != 10'(PKT_MAX)) begin
                    done_seen = 1'b1;
                end
                last_block = pkt_block;
            end
            pkt_pos = '0;
            pkt_kind = KIND_NONE;
            pkt_block = '0;
        end
        res.transfer_done = done_seen;
        res.last_block_seen = last_block;
        res.total_bytes = byte_count;
        res.total_blocks = block_count;
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    task automatic compare_beat(result_beat_t want, result_beat_t got);
        check_field("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
        check_field("payload_valid", 32'(want.payload_valid), 32'(got.payload_valid));
        check_field("packet_end", 32'(want.packet_end), 32'(got.packet_end));
        check_field("packet_status", 32'(want.packet_status), 32'(got.packet_status));
        check_field("transfer_done", 32'(want.transfer_done), 32'(got.transfer_done));
        check_field("last_block_seen", 32'(want.last_block_seen),
                    32'(got.last_block_seen));
        check_field("total_bytes", want.total_bytes, got.total_bytes);
        check_field("total_blocks", want.total_blocks, got.total_blocks);
    endtask

    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            return 0;
        end
        if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge aclk) begin
        s_taken = aresetn && s_valid && s_ready;
        m_taken = aresetn && m_valid && m_ready;
        if (aresetn && cfg_valid && cfg_ready) begin
            next_block = cfg_data;
        end
        if (s_taken) begin
            expect_q.insert(expect_q.size(), rx_predict(s_data));
        end
        if (m_taken) begin
            if (expect_q.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing expected, expected none, actual %0h",
                         $time, m_data);
            end else begin
                compare_beat(expect_q.pop_front(), m_data);
            end
        end
    end

    always @(negedge aclk) begin
        if (!s_valid || s_taken) begin
            if (s_taken) begin
                void'(send_q.pop_front());
                send_gap = pick_gap(send_calm);
            end
            if (send_gap > 0) begin
                send_gap--;
                s_valid <= 1'b0;
            end else if (send_q.size() > 0) begin
                s_valid <= 1'b1;
                s_data <= send_q[0];
            end else begin
                s_valid <= 1'b0;
            end
        end
        if ($urandom_range(0, 299) == 0) begin
            send_calm = !send_calm;
        end
    end

    always @(negedge aclk) begin
        if (m_taken) begin
            stall_left = pick_gap(recv_calm);
        end
        if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
        if ($urandom_range(0, 299) == 0) begin
            recv_calm = !recv_calm;
        end
    end

    task automatic push_beat(logic [7:0] b, logic eop);
        rx_beat_t beat;
        beat.rx_byte = b;
        beat.end_of_packet = eop;
        send_q.insert(send_q.size(), beat);
        stim_bytes++;
    endtask

    task automatic add_packet(logic [7:0] opc, logic [15:0] blk, int unsigned len);
        logic [7:0] b;
        for (int unsigned i = 0; i < len; i++) begin
            case (i)
                1: b = opc;
                2: b = blk[15:8];
                3: b = blk[7:0];
                default: b = 8'($urandom_range(0, 255));
            endcase
            push_beat(b, i == len - 1);
        end
        if (opc == OPC_DATA && blk == gen_block && len > HEADER_BYTES) begin
            gen_block = gen_block + 16'd1;
        end
    endtask

    task automatic rand_packet();
        int unsigned r;
        int unsigned q;
        logic [7:0] opc;
        r = $urandom_range(0, 99);
        q = $urandom_range(0, 19);
        if (r < 62) begin
            add_packet(OPC_DATA, gen_block, (q < 2) ? 4 : $urandom_range(5, 40));
        end else if (r < 72) begin
            add_packet(OPC_DATA, gen_block + 16'($urandom_range(1, 65535)),
                       $urandom_range(4, 40));
        end else if (r < 80) begin
            add_packet(OPC_ERROR, 16'($urandom_range(0, 65535)), $urandom_range(4, 30));
        end else if (r < 88) begin
            opc = 8'($urandom_range(0, 255));
            if (opc == OPC_DATA || opc == OPC_ERROR) begin
                opc = opc ^ 8'h80;
            end
            add_packet(opc, gen_block, $urandom_range(4, 30));
        end else begin
            add_packet(8'($urandom_range(0, 255)), gen_block, $urandom_range(1, 3));
        end
    endtask

    task automatic fill_random();
        int unsigned start;
        start = stim_bytes;
        while (stim_bytes - start < PHASE_BYTES) begin
            rand_packet();
        end
    endtask

    task automatic drain_wait();
        do @(posedge aclk); while (send_q.size() != 0 || s_valid || expect_q.size() != 0);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_first_block(logic [15:0] v);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        gen_block = v;
    endtask

    initial begin
        for (int unsigned cyc = 0; cyc < RUN_LIMIT; cyc++) begin
            @(posedge aclk);
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Runts, an error packet and an unknown opcode must leave all state alone.
        push_beat(8'h00, 1'b1);
        add_packet(OPC_DATA, gen_block, 3);
        add_packet(OPC_ERROR, gen_block, 4);
        add_packet(8'hFF, gen_block, 5);
        // A full-length block must not end the transfer.
        add_packet(OPC_DATA, gen_block, PKT_MAX);
        push_beat(8'hFF, 1'b0);
        push_beat(OPC_DATA, 1'b0);
        push_beat(gen_block[15:8], 1'b0);
        push_beat(gen_block[7:0], 1'b0);
        push_beat(8'h00, 1'b0);
        push_beat(8'hFF, 1'b1);
        gen_block = gen_block + 16'd1;
        // Header only, then a stale block: both ignored.
        add_packet(OPC_DATA, gen_block, 4);
        add_packet(OPC_DATA, gen_block - 16'd1, 5);
        fill_random();

        for (int p = 1; p <= 3; p++) begin
            drain_wait();
            case (p)
                1: write_first_block(16'h0000);
                2: write_first_block(16'hFFFF);
                default: write_first_block(16'($urandom_range(1, 65534)));
            endcase
            if (p == 3) begin
                add_packet(OPC_DATA, gen_block, 1026);
            end
            fill_random();
        end
        drain_wait();

        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/tdpr_pkg.sv
rtl/tdpr_parser.sv
rtl/tftp_data_packet_receiver_top.sv
tb/sv/tb_top.sv
